// File: src/dwr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwr_pkg
// Shared constants, types and the control store of the deque sequencer.
// ----------------------------------------------------------------------------
package dwr_pkg;

  localparam int unsigned DEPTH  = 32;
  localparam int unsigned PTR_W  = $clog2(DEPTH);
  localparam int unsigned OCC_W  = $clog2(DEPTH + 1);
  localparam int unsigned POS_W  = 6;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned OP_W   = 3;
  localparam int unsigned UPC_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_REMOVE_AT  = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_POP_BACK   = 3'd4,
    OP_LIST       = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_NONE  = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  // Jump conditions of a control word.
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_DISPATCH,
    C_FULL,
    C_EMPTY,
    C_POS_BAD,
    C_SHIFT_DONE,
    C_LIST_MORE
  } cond_e;

  // Datapath actions of a control word.
  typedef enum logic [3:0] {
    A_NONE,
    A_PUSH_FRONT,
    A_PUSH_BACK,
    A_POP_FRONT,
    A_POP_BACK,
    A_LOAD_POS,
    A_READ_NEXT,
    A_SHIFT_WRITE,
    A_DEC_OCC,
    A_CLR_CNT,
    A_READ_CUR,
    A_INC_CNT
  } act_e;

  typedef struct packed {
    cond_e            cond;
    logic [UPC_W-1:0] target;
    act_e             act;
    logic             emit;
    status_e          status;
    logic             list_emit;
  } uword_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    logic    accept;
    act_e    act;
    logic    emit;
    status_e status;
    logic    list_emit;
  } dp_ctrl_t;

  // Flags from the datapath to the sequencer.
  typedef struct packed {
    logic full;
    logic empty;
    logic pos_bad;
    logic shift_done;
    logic list_last;
    logic out_space;
  } dp_flags_t;

  // Control store addresses.
  localparam logic [UPC_W-1:0] U_IDLE   = 5'd0;
  localparam logic [UPC_W-1:0] U_PF0    = 5'd1;
  localparam logic [UPC_W-1:0] U_PF1    = 5'd2;
  localparam logic [UPC_W-1:0] U_PB0    = 5'd3;
  localparam logic [UPC_W-1:0] U_PB1    = 5'd4;
  localparam logic [UPC_W-1:0] U_RM0    = 5'd5;
  localparam logic [UPC_W-1:0] U_RM1    = 5'd6;
  localparam logic [UPC_W-1:0] U_RM2    = 5'd7;
  localparam logic [UPC_W-1:0] U_RM3    = 5'd8;
  localparam logic [UPC_W-1:0] U_RMEND  = 5'd9;
  localparam logic [UPC_W-1:0] U_POPF0  = 5'd10;
  localparam logic [UPC_W-1:0] U_POPF1  = 5'd11;
  localparam logic [UPC_W-1:0] U_POPB0  = 5'd12;
  localparam logic [UPC_W-1:0] U_POPB1  = 5'd13;
  localparam logic [UPC_W-1:0] U_LS0    = 5'd14;
  localparam logic [UPC_W-1:0] U_LS1    = 5'd15;
  localparam logic [UPC_W-1:0] U_LS2    = 5'd16;
  localparam logic [UPC_W-1:0] U_LS3    = 5'd17;
  localparam logic [UPC_W-1:0] U_EOK    = 5'd18;
  localparam logic [UPC_W-1:0] U_EEMPTY = 5'd19;
  localparam logic [UPC_W-1:0] U_ENONE  = 5'd20;
  localparam logic [UPC_W-1:0] U_EFULL  = 5'd21;

  // Entry point of the routine for each operation code.
  function automatic logic [UPC_W-1:0] dispatch(input logic [OP_W-1:0] op);
    logic [UPC_W-1:0] addr;
    case (op)
      OP_PUSH_FRONT: addr = U_PF0;
      OP_PUSH_BACK:  addr = U_PB0;
      OP_REMOVE_AT:  addr = U_RM0;
      OP_POP_FRONT:  addr = U_POPF0;
      OP_POP_BACK:   addr = U_POPB0;
      OP_LIST:       addr = U_LS0;
      default:       addr = U_IDLE;
    endcase
    return addr;
  endfunction

  function automatic uword_t mk(input cond_e c, input logic [UPC_W-1:0] t, input act_e a,
                                input logic e, input status_e s, input logic l);
    uword_t w;
    w.cond      = c;
    w.target    = t;
    w.act       = a;
    w.emit      = e;
    w.status    = s;
    w.list_emit = l;
    return w;
  endfunction

  // The control program.
  function automatic uword_t ucode(input logic [UPC_W-1:0] upc);
    uword_t w;
    case (upc)
      U_IDLE:   w = mk(C_DISPATCH,   U_IDLE,   A_NONE,        1'b0, ST_OK,    1'b0);
      U_PF0:    w = mk(C_FULL,       U_EFULL,  A_NONE,        1'b0, ST_OK,    1'b0);
      U_PF1:    w = mk(C_ALWAYS,     U_EOK,    A_PUSH_FRONT,  1'b0, ST_OK,    1'b0);
      U_PB0:    w = mk(C_FULL,       U_EFULL,  A_NONE,        1'b0, ST_OK,    1'b0);
      U_PB1:    w = mk(C_ALWAYS,     U_EOK,    A_PUSH_BACK,   1'b0, ST_OK,    1'b0);
      U_RM0:    w = mk(C_EMPTY,      U_EEMPTY, A_NONE,        1'b0, ST_OK,    1'b0);
      U_RM1:    w = mk(C_POS_BAD,    U_ENONE,  A_LOAD_POS,    1'b0, ST_OK,    1'b0);
      U_RM2:    w = mk(C_SHIFT_DONE, U_RMEND,  A_READ_NEXT,   1'b0, ST_OK,    1'b0);
      U_RM3:    w = mk(C_ALWAYS,     U_RM2,    A_SHIFT_WRITE, 1'b0, ST_OK,    1'b0);
      U_RMEND:  w = mk(C_ALWAYS,     U_EOK,    A_DEC_OCC,     1'b0, ST_OK,    1'b0);
      U_POPF0:  w = mk(C_EMPTY,      U_EEMPTY, A_NONE,        1'b0, ST_OK,    1'b0);
      U_POPF1:  w = mk(C_ALWAYS,     U_EOK,    A_POP_FRONT,   1'b0, ST_OK,    1'b0);
      U_POPB0:  w = mk(C_EMPTY,      U_EEMPTY, A_NONE,        1'b0, ST_OK,    1'b0);
      U_POPB1:  w = mk(C_ALWAYS,     U_EOK,    A_POP_BACK,    1'b0, ST_OK,    1'b0);
      U_LS0:    w = mk(C_EMPTY,      U_EEMPTY, A_CLR_CNT,     1'b0, ST_OK,    1'b0);
      U_LS1:    w = mk(C_NEVER,      U_IDLE,   A_READ_CUR,    1'b0, ST_OK,    1'b0);
      U_LS2:    w = mk(C_LIST_MORE,  U_LS1,    A_INC_CNT,     1'b1, ST_OK,    1'b1);
      U_LS3:    w = mk(C_ALWAYS,     U_IDLE,   A_NONE,        1'b0, ST_OK,    1'b0);
      U_EOK:    w = mk(C_ALWAYS,     U_IDLE,   A_NONE,        1'b1, ST_OK,    1'b0);
      U_EEMPTY: w = mk(C_ALWAYS,     U_IDLE,   A_NONE,        1'b1, ST_EMPTY, 1'b0);
      U_ENONE:  w = mk(C_ALWAYS,     U_IDLE,   A_NONE,        1'b1, ST_NONE,  1'b0);
      U_EFULL:  w = mk(C_ALWAYS,     U_IDLE,   A_NONE,        1'b1, ST_FULL,  1'b0);
      default:  w = mk(C_ALWAYS,     U_IDLE,   A_NONE,        1'b0, ST_OK,    1'b0);
    endcase
    return w;
  endfunction

endpackage

// File: src/dwr_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwr_in_if
// Command channel: operation code, value and position with valid and ready.
// ----------------------------------------------------------------------------
interface dwr_in_if
  import dwr_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic        [OP_W-1:0]   op;
  logic signed [DATA_W-1:0] value;
  logic        [POS_W-1:0]  position;

  modport source (output valid, output op, output value, output position, input ready);
  modport sink   (input valid, input op, input value, input position, output ready);
endinterface

// File: src/dwr_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwr_out_if
// Result channel: status, listed item and last flag with valid and ready.
// ----------------------------------------------------------------------------
interface dwr_out_if
  import dwr_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic        [1:0]        status;
  logic signed [DATA_W-1:0] item;
  logic                     last;

  modport source (output valid, output status, output item, output last, input ready);
  modport sink   (input valid, input status, input item, input last, output ready);
endinterface

// File: src/dwr_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwr_seq
// Micro-program counter, control store lookup and jump logic.
// ----------------------------------------------------------------------------
module dwr_seq
  import dwr_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [OP_W-1:0] in_op_i,
  input  dp_flags_t       flags_i,
  output logic            in_ready_o,
  output dp_ctrl_t        ctrl_o
);

  logic [UPC_W-1:0] upc_q, upc_d;
  uword_t           uw;
  logic             stall;
  logic             accept;
  logic             take;

  assign uw         = ucode(upc_q);
  assign in_ready_o = (upc_q == U_IDLE);
  assign accept     = in_ready_o && in_valid_i;
  // A step that emits waits until the result register can take the transfer.
  assign stall      = uw.emit && !flags_i.out_space;

  always_comb begin
    case (uw.cond)
      C_NEVER:      take = 1'b0;
      C_ALWAYS:     take = 1'b1;
      C_DISPATCH:   take = accept;
      C_FULL:       take = flags_i.full;
      C_EMPTY:      take = flags_i.empty;
      C_POS_BAD:    take = flags_i.pos_bad;
      C_SHIFT_DONE: take = flags_i.shift_done;
      C_LIST_MORE:  take = !flags_i.list_last;
      default:      take = 1'b0;
    endcase
  end

  always_comb begin
    upc_d = upc_q;
    if (uw.cond == C_DISPATCH) begin
      if (accept) begin
        upc_d = dispatch(in_op_i);
      end
    end else if (!stall) begin
      upc_d = take ? uw.target : upc_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= U_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  always_comb begin
    ctrl_o.accept    = accept;
    ctrl_o.act       = stall ? A_NONE : uw.act;
    ctrl_o.emit      = uw.emit && !stall;
    ctrl_o.status    = uw.status;
    ctrl_o.list_emit = uw.list_emit;
  end

endmodule

// File: src/dwr_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwr_datapath
// Entry memory, front pointer, occupancy, loop counter and result register.
// ----------------------------------------------------------------------------
module dwr_datapath
  import dwr_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  dp_ctrl_t                 ctrl_i,
  input  logic signed [DATA_W-1:0] value_i,
  input  logic        [POS_W-1:0]  position_i,
  input  logic                     out_ready_i,
  output dp_flags_t                flags_o,
  output logic                     out_valid_o,
  output logic        [1:0]        out_status_o,
  output logic signed [DATA_W-1:0] out_item_o,
  output logic                     out_last_o
);

  localparam int unsigned SUM_W = OCC_W + 1;
  localparam int unsigned CMP_W = (POS_W > OCC_W) ? POS_W : OCC_W;

  logic signed [DATA_W-1:0] mem [DEPTH];
  logic signed [DATA_W-1:0] rdata_q;
  logic signed [DATA_W-1:0] value_q;
  logic        [POS_W-1:0]  pos_q;

  logic [PTR_W-1:0] front_q, front_d;
  logic [OCC_W-1:0] occ_q, occ_d;
  logic [OCC_W-1:0] cnt_q, cnt_d;
  logic [OCC_W-1:0] cnt_inc;

  logic [POS_W-1:0] pos_eff;
  logic [POS_W-1:0] pos_m1;
  logic [OCC_W-1:0] offs;
  logic [SUM_W-1:0] sum;
  logic [PTR_W-1:0] place;
  logic [PTR_W-1:0] front_dec;
  logic [PTR_W-1:0] front_inc;

  logic                     we, re;
  logic [PTR_W-1:0]         waddr;
  logic signed [DATA_W-1:0] wdata;

  logic                     out_valid_q;
  logic        [1:0]        out_status_q;
  logic signed [DATA_W-1:0] out_item_q;
  logic                     out_last_q;

  assign cnt_inc   = cnt_q + 1'b1;
  assign pos_eff   = (pos_q == '0) ? POS_W'(1) : pos_q;
  assign pos_m1    = pos_eff - 1'b1;
  assign front_dec = (front_q == '0) ? PTR_W'(DEPTH - 1) : front_q - 1'b1;
  assign front_inc = (front_q == PTR_W'(DEPTH - 1)) ? '0 : front_q + 1'b1;

  // Logical offset to physical place; one compare and subtract wraps the ring.
  always_comb begin
    case (ctrl_i.act)
      A_PUSH_BACK: offs = occ_q;
      A_READ_NEXT: offs = cnt_inc;
      default:     offs = cnt_q;
    endcase
  end

  assign sum   = SUM_W'(front_q) + SUM_W'(offs);
  assign place = (sum >= SUM_W'(DEPTH)) ? PTR_W'(sum - SUM_W'(DEPTH)) : PTR_W'(sum);

  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = place;
    wdata = value_q;
    case (ctrl_i.act)
      A_PUSH_FRONT: begin
        we    = 1'b1;
        waddr = front_dec;
      end
      A_PUSH_BACK: begin
        we = 1'b1;
      end
      A_SHIFT_WRITE: begin
        we    = 1'b1;
        wdata = rdata_q;
      end
      A_READ_NEXT, A_READ_CUR: begin
        re = 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[place];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      value_q <= value_i;
      pos_q   <= position_i;
    end
  end

  always_comb begin
    front_d = front_q;
    occ_d   = occ_q;
    cnt_d   = cnt_q;
    case (ctrl_i.act)
      A_PUSH_FRONT: begin
        front_d = front_dec;
        occ_d   = occ_q + 1'b1;
      end
      A_PUSH_BACK: occ_d = occ_q + 1'b1;
      A_POP_FRONT: begin
        front_d = front_inc;
        occ_d   = occ_q - 1'b1;
      end
      A_POP_BACK, A_DEC_OCC: occ_d = occ_q - 1'b1;
      A_LOAD_POS:            cnt_d = OCC_W'(pos_m1);
      A_CLR_CNT:             cnt_d = '0;
      A_SHIFT_WRITE, A_INC_CNT: cnt_d = cnt_inc;
      default:               cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      occ_q   <= '0;
      cnt_q   <= '0;
    end else begin
      front_q <= front_d;
      occ_q   <= occ_d;
      cnt_q   <= cnt_d;
    end
  end

  always_comb begin
    flags_o.full       = (occ_q == OCC_W'(DEPTH));
    flags_o.empty      = (occ_q == '0);
    flags_o.pos_bad    = (CMP_W'(pos_eff) > CMP_W'(occ_q));
    flags_o.shift_done = (cnt_inc >= occ_q);
    flags_o.list_last  = (cnt_inc == occ_q);
    flags_o.out_space  = !out_valid_q || out_ready_i;
  end

  // Result register: loaded by an emitting step, cleared once the transfer is taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit) begin
      out_status_q <= ctrl_i.status;
      out_item_q   <= ctrl_i.list_emit ? rdata_q : '0;
      out_last_q   <= ctrl_i.list_emit ? flags_o.list_last : 1'b1;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_item_o   = out_item_q;
  assign out_last_o   = out_last_q;

endmodule

// File: src/deque_with_remove_at.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deque_with_remove_at
// Bounded deque of signed 32-bit values with removal at a position and listing.
// ----------------------------------------------------------------------------
// One command is taken at a time, whenever the sequencer is back at its idle
// step. Push and pop check for room or an entry, act, then emit the result.
// Remove at position p moves each entry behind p one place toward the front,
// and listing emits the entries in order from the front. Both loops follow from
// the single-port entry memory with its registered read: each shifted or
// listed entry needs a read step and a write or emit step. A full result
// register that is not drained holds the sequencer at its emitting step.
module deque_with_remove_at
  import dwr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  dwr_in_if.sink    in_i,
  dwr_out_if.source out_o
);

  dp_ctrl_t  ctrl;
  dp_flags_t flags;

  dwr_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_op_i    (in_i.op),
    .flags_i    (flags),
    .in_ready_o (in_i.ready),
    .ctrl_o     (ctrl)
  );

  dwr_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .value_i      (in_i.value),
    .position_i   (in_i.position),
    .out_ready_i  (out_o.ready),
    .flags_o      (flags),
    .out_valid_o  (out_o.valid),
    .out_status_o (out_o.status),
    .out_item_o   (out_o.item),
    .out_last_o   (out_o.last)
  );

endmodule
